@@ sv/yin_pkg.sv @@
// shared constants for the yin pitch detector
package yin_pkg;

	// default build values
	localparam int MAX_SAMPLES_DEF = 1024;
	localparam int SAMPLE_BITS_DEF = 16;

	// fixed field widths
	localparam int SAMPLE_W    = 16;
	localparam int RATE_W      = 18;
	localparam int THR_W       = 16;
	localparam int CFG_DATA_W  = 18;
	localparam int CFG_INDEX_W = 2;
	localparam int PERIOD_W    = 9;
	localparam int FREQ_W      = 25;
	localparam int FRAC_BITS   = 8;
	localparam int DIVIDEND_W  = RATE_W + FRAC_BITS + 1;

	// unity in the threshold's q0.16 scale
	localparam int THR_ONE = 65536;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_RATE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD   = 2'd1;

	// register reset values
	localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;
	localparam logic [THR_W-1:0]  THR_RESET  = 16'd9830;

endpackage

@@ sv/yin_mul.sv @@
// serial shift-add multiplier, one multiplier bit per cycle
module yin_mul #(
	parameter int W = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic           done,
	output logic [2*W-1:0] product
);

	localparam int CNTW = $clog2(W + 1);

	logic [2*W-1:0] acc_q;
	logic [W-1:0]   a_q;
	logic [CNTW-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [W:0]     top_c;

	// add multiplicand into the upper half when the current multiplier bit is set
	assign top_c = {1'b0, acc_q[2*W-1:W]} + (acc_q[0] ? {1'b0, a_q} : {(W+1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			a_q    <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			a_q    <= a;
			acc_q  <= {{W{1'b0}}, b};
			cnt_q  <= CNTW'(W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			acc_q <= {top_c, acc_q[W-1:1]};
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNTW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

@@ sv/yin_div.sv @@
// restoring divider, one quotient bit per cycle
module yin_div #(
	parameter int NW    = 27,
	parameter int DEN_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NW-1:0]    num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NW-1:0]    quot
);

	localparam int CNTW = $clog2(NW + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NW-1:0]    quo_q;
	logic [CNTW-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   shifted_c;
	logic [DEN_W:0]   diff_c;
	logic             ge_c;

	// shift in the next dividend bit and try the subtract
	assign shifted_c = {rem_q, quo_q[NW-1]};
	assign diff_c    = shifted_c - {1'b0, den_q};
	assign ge_c      = shifted_c >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			den_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			rem_q  <= '0;
			den_q  <= den;
			quo_q  <= num;
			cnt_q  <= CNTW'(NW);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rem_q <= ge_c ? diff_c[DEN_W-1:0] : shifted_c[DEN_W-1:0];
			quo_q <= {quo_q[NW-2:0], ge_c};
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNTW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

@@ sv/yin_pitch_detector_unit.sv @@
// yin pitch detector top level: frame store, difference mac and search sequencer
//
// Samples are taken one per cycle into a two-read-port frame memory; the request
// with last set closes a frame of n samples and the block then stalls its input
// while it analyzes. For each lag tau from 1 to n/2-1 a single multiply-accumulate
// path walks the frame and sums its squared differences. Each lag examined by
// the threshold search or the descent to the minimum adds two serial products,
// and a found period adds the serial frequency divide. One result request leaves
// per frame; it sits in an output register, so the next frame may load while it
// waits.
module yin_pitch_detector_unit #(
	parameter int MAX_SAMPLES = yin_pkg::MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = yin_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  logic signed [yin_pkg::SAMPLE_W-1:0] sample,
	input  logic                                last,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic                                found,
	output logic [yin_pkg::PERIOD_W-1:0]        period,
	output logic [yin_pkg::FREQ_W-1:0]          frequency_q8,
	input  logic                                cfg_write,
	input  logic [yin_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [yin_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int SW  = (SAMPLE_BITS < yin_pkg::SAMPLE_W) ? SAMPLE_BITS : yin_pkg::SAMPLE_W;
	localparam int CW  = $clog2(MAX_SAMPLES + 1);
	localparam int AW  = $clog2(MAX_SAMPLES);
	localparam int SQW = 2 * SW;
	localparam int DW  = SQW + CW;
	localparam int W   = DW + CW;
	localparam int PW  = 2 * W;
	localparam int DVW = yin_pkg::DIVIDEND_W;

	localparam logic [3:0] S_LOAD   = 4'd0;
	localparam logic [3:0] S_MAC    = 4'd1;
	localparam logic [3:0] S_ACC    = 4'd2;
	localparam logic [3:0] S_EVAL   = 4'd3;
	localparam logic [3:0] S_MUL1   = 4'd4;
	localparam logic [3:0] S_MUL2   = 4'd5;
	localparam logic [3:0] S_DECIDE = 4'd6;
	localparam logic [3:0] S_NEXT   = 4'd7;
	localparam logic [3:0] S_DIV    = 4'd8;
	localparam logic [3:0] S_FIN    = 4'd9;

	localparam logic [1:0] M_SEARCH = 2'd0;
	localparam logic [1:0] M_DESC   = 2'd1;
	localparam logic [1:0] M_DONE   = 2'd2;

	logic [3:0]    state_q;
	logic [1:0]    mode_q;
	logic [yin_pkg::RATE_W-1:0] rate_q;
	logic [yin_pkg::THR_W-1:0]  thr_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] maxtau_q;
	logic [CW-1:0] tau_q;
	logic [CW-1:0] issue_q;
	logic [CW-1:0] lim_q;
	logic [CW-1:0] cand_q;
	logic [CW-1:0] n_new_c;
	logic [CW-1:0] addr_b_c;

	logic signed [SW-1:0] mem [MAX_SAMPLES];
	logic signed [SW-1:0] rd_a_s1;
	logic signed [SW-1:0] rd_b_s1;
	logic                 v_s1;
	logic                 v_s2;
	logic [SQW-1:0]       sq_s2;
	logic signed [SW:0]   diff_c;
	logic signed [2*SW+1:0] sqf_c;

	logic [DW-1:0] sum_q;
	logic [W-1:0]  run_q;
	logic [W-1:0]  pnum_q;
	logic [W-1:0]  pnum_c;
	logic [W-1:0]  cur_num_c;
	logic [W-1:0]  cur_den_c;
	logic [W-1:0]  prev_num_q;
	logic [W-1:0]  prev_den_q;
	logic [PW-1:0] p1_q;
	logic          less_q;

	logic          mul_start;
	logic [W-1:0]  mul_a;
	logic [W-1:0]  mul_b;
	logic          mul_done;
	logic [PW-1:0] mul_prod;

	logic           div_start;
	logic [DVW-1:0] div_num_c;
	logic           div_done;
	logic [DVW-1:0] div_quo;

	logic eval_go_c;
	logic finish_c;

	logic                        res_found_q;
	logic [yin_pkg::PERIOD_W-1:0] res_period_q;
	logic [yin_pkg::FREQ_W-1:0]   res_freq_q;
	logic                        out_valid_q;
	logic                        found_q;
	logic [yin_pkg::PERIOD_W-1:0] period_q;
	logic [yin_pkg::FREQ_W-1:0]   freq_q;

	// frame length after the current request, saturating at the store depth
	assign n_new_c  = (count_q < CW'(MAX_SAMPLES)) ? count_q + 1'b1 : count_q;
	assign addr_b_c = issue_q + tau_q;

	// frame store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD && sample_valid && count_q < CW'(MAX_SAMPLES)) begin
			mem[count_q[AW-1:0]] <= sample[SW-1:0];
		end
		rd_a_s1 <= mem[issue_q[AW-1:0]];
		rd_b_s1 <= mem[addr_b_c[AW-1:0]];
	end

	// squared difference of one sample pair
	assign diff_c = $signed({rd_a_s1[SW-1], rd_a_s1}) - $signed({rd_b_s1[SW-1], rd_b_s1});
	assign sqf_c  = diff_c * diff_c;

	// normalized difference as an exact fraction, 1/1 on a zero running sum
	assign pnum_c    = sum_q * tau_q;
	assign cur_num_c = (run_q == '0) ? W'(1) : pnum_q;
	assign cur_den_c = (run_q == '0) ? W'(1) : run_q;

	assign eval_go_c = (mode_q == M_SEARCH && tau_q >= CW'(2)) || mode_q == M_DESC;
	assign finish_c  = (tau_q + 1'b1 >= maxtau_q) || mode_q == M_DONE;

	// cross-multiplication operands: threshold test or descent test
	always_comb begin
		mul_start = 1'b0;
		mul_a     = cur_num_c;
		mul_b     = (mode_q == M_SEARCH) ? W'(yin_pkg::THR_ONE) : prev_den_q;
		if (state_q == S_EVAL) begin
			mul_start = eval_go_c;
		end else if (state_q == S_MUL1) begin
			mul_start = mul_done;
			mul_a     = (mode_q == M_SEARCH) ? W'(thr_q) : prev_num_q;
			mul_b     = cur_den_c;
		end
	end

	assign div_start = state_q == S_NEXT && finish_c && mode_q != M_SEARCH;
	assign div_num_c = DVW'({rate_q, {yin_pkg::FRAC_BITS{1'b0}}}) + DVW'(cand_q[CW-1:1]);

	yin_mul #(.W(W)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_prod)
	);

	yin_div #(.NW(DVW), .DEN_W(CW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num_c),
		.den    (cand_q),
		.done   (div_done),
		.quot   (div_quo)
	);

	// sequencer, accumulator and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			mode_q       <= M_SEARCH;
			rate_q       <= yin_pkg::RATE_RESET;
			thr_q        <= yin_pkg::THR_RESET;
			count_q      <= '0;
			n_q          <= '0;
			maxtau_q     <= '0;
			tau_q        <= '0;
			issue_q      <= '0;
			lim_q        <= '0;
			cand_q       <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			sq_s2        <= '0;
			sum_q        <= '0;
			run_q        <= '0;
			pnum_q       <= '0;
			prev_num_q   <= '0;
			prev_den_q   <= '0;
			p1_q         <= '0;
			less_q       <= 1'b0;
			res_found_q  <= 1'b0;
			res_period_q <= '0;
			res_freq_q   <= '0;
			out_valid_q  <= 1'b0;
			found_q      <= 1'b0;
			period_q     <= '0;
			freq_q       <= '0;
		end else begin
			// configuration writes
			if (cfg_write) begin
				unique case (cfg_index)
					yin_pkg::REG_SAMPLE_RATE: rate_q <= cfg_data[yin_pkg::RATE_W-1:0];
					yin_pkg::REG_THRESHOLD:   thr_q  <= cfg_data[yin_pkg::THR_W-1:0];
					default: ;
				endcase
			end

			// output register drains on a taken request
			if (out_valid_q && !result_stall && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end

			// mac pipeline
			v_s1 <= state_q == S_MAC && issue_q < lim_q;
			v_s2 <= v_s1;
			if (v_s1) begin
				sq_s2 <= sqf_c[SQW-1:0];
			end

			unique case (state_q)
				S_LOAD: begin
					if (sample_valid) begin
						if (last) begin
							count_q  <= '0;
							n_q      <= n_new_c;
							maxtau_q <= n_new_c >> 1;
							tau_q    <= CW'(1);
							run_q    <= '0;
							mode_q   <= M_SEARCH;
							issue_q  <= '0;
							sum_q    <= '0;
							lim_q    <= n_new_c - 1'b1;
							if ((n_new_c >> 1) <= CW'(2)) begin
								res_found_q  <= 1'b0;
								res_period_q <= '0;
								res_freq_q   <= '0;
								state_q      <= S_FIN;
							end else begin
								state_q <= S_MAC;
							end
						end else begin
							count_q <= n_new_c;
						end
					end
				end
				S_MAC: begin
					if (issue_q < lim_q) begin
						issue_q <= issue_q + 1'b1;
					end
					if (v_s2) begin
						sum_q <= sum_q + DW'(sq_s2);
					end
					if (issue_q >= lim_q && !v_s1 && !v_s2) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					run_q   <= run_q + W'(sum_q);
					pnum_q  <= pnum_c;
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					state_q <= eval_go_c ? S_MUL1 : S_NEXT;
				end
				S_MUL1: begin
					if (mul_done) begin
						p1_q    <= mul_prod;
						state_q <= S_MUL2;
					end
				end
				S_MUL2: begin
					if (mul_done) begin
						less_q  <= p1_q < mul_prod;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					case (mode_q)
						M_SEARCH: begin
							if (less_q) begin
								mode_q     <= M_DESC;
								prev_num_q <= cur_num_c;
								prev_den_q <= cur_den_c;
								cand_q     <= tau_q;
							end
						end
						M_DESC: begin
							if (less_q) begin
								prev_num_q <= cur_num_c;
								prev_den_q <= cur_den_c;
								cand_q     <= tau_q;
							end else begin
								mode_q <= M_DONE;
							end
						end
						default: ;
					endcase
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (finish_c) begin
						if (mode_q != M_SEARCH) begin
							res_found_q  <= 1'b1;
							res_period_q <= yin_pkg::PERIOD_W'(cand_q);
							state_q      <= S_DIV;
						end else begin
							res_found_q  <= 1'b0;
							res_period_q <= '0;
							res_freq_q   <= '0;
							state_q      <= S_FIN;
						end
					end else begin
						tau_q   <= tau_q + 1'b1;
						issue_q <= '0;
						sum_q   <= '0;
						lim_q   <= n_q - (tau_q + 1'b1);
						state_q <= S_MAC;
					end
				end
				S_DIV: begin
					if (div_done) begin
						res_freq_q <= yin_pkg::FREQ_W'(div_quo);
						state_q    <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || !result_stall) begin
						out_valid_q <= 1'b1;
						found_q     <= res_found_q;
						period_q    <= res_period_q;
						freq_q      <= res_freq_q;
						state_q     <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign sample_stall = state_q != S_LOAD;
	assign result_valid = out_valid_q;
	assign found        = found_q;
	assign period       = period_q;
	assign frequency_q8 = freq_q;

`ifndef SYNTHESIS
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !found |-> period == '0 && frequency_q8 == '0)
		else $error("result without a period carries nonzero fields");

	a_mac_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> state_q == S_MAC)
		else $error("sample pair in flight outside the difference pass");

	a_tau_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MAC |-> tau_q < maxtau_q && tau_q != '0)
		else $error("lag outside its range during the difference pass");

	a_div_period: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> cand_q >= CW'(2) && mode_q != M_SEARCH)
		else $error("frequency divide started without a valid period");
`endif

endmodule

@@ verif/yin_pitch_detector_unit_test.sv @@
// testbench for the yin pitch detector: directed frames, random tones and noise, predicted results
module yin_pitch_detector_unit_test;

	localparam int MAX_SAMPLES_DEF = yin_pkg::MAX_SAMPLES_DEF;
	localparam int SAMPLE_W        = yin_pkg::SAMPLE_W;
	localparam int PERIOD_W        = yin_pkg::PERIOD_W;
	localparam int FREQ_W          = yin_pkg::FREQ_W;
	localparam int CFG_INDEX_W     = yin_pkg::CFG_INDEX_W;
	localparam int CFG_DATA_W      = yin_pkg::CFG_DATA_W;
	localparam int RATE_W          = yin_pkg::RATE_W;
	localparam int THR_W           = yin_pkg::THR_W;
	localparam int THR_ONE         = yin_pkg::THR_ONE;
	localparam logic [RATE_W-1:0] RATE_RESET = yin_pkg::RATE_RESET;
	localparam logic [THR_W-1:0]  THR_RESET  = yin_pkg::THR_RESET;
	localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_RATE = yin_pkg::REG_SAMPLE_RATE;
	localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD   = yin_pkg::REG_THRESHOLD;

	localparam int FRAME_MAX = MAX_SAMPLES_DEF;
	localparam int CYCLE_LIMIT = 4000000;

	typedef struct packed {
		logic                found;
		logic [PERIOD_W-1:0] period;
		logic [FREQ_W-1:0]   freq;
	} pitch_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] smp;
		logic                       lst;
		logic                       typed;
		pitch_t                     res;
	} stim_row_t;

	logic                       clk;
	logic                       arst_n;
	logic                       sample_valid;
	logic                       sample_stall;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last;
	logic                       result_valid;
	logic                       result_stall;
	logic                       found;
	logic [PERIOD_W-1:0]        period;
	logic [FREQ_W-1:0]          frequency_q8;
	logic                       cfg_write;
	logic [CFG_INDEX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;

	yin_pitch_detector_unit dut (.*);

	// predictor state
	logic [RATE_W-1:0] rate_reg;
	logic [THR_W-1:0]  thr_reg;
	int                frame_buf [FRAME_MAX];
	int                frame_len;

	pitch_t pitch_queue [$];
	int     mismatches;
	int     items_sent;
	int     frames_sent;
	int     burst_left;
	int     cycles;
	bit     hold_request;

	// clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// cycle limit
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	function automatic bit frac_below(logic [63:0] n1, logic [63:0] d1,
			logic [63:0] n2, logic [63:0] d2);
		logic [127:0] a;
		logic [127:0] b;
		a = 128'(n1) * 128'(d2);
		b = 128'(n2) * 128'(d1);
		return a < b;
	endfunction

	// yin analysis of the frame held in frame_buf
	function automatic pitch_t analyze_frame();
		logic [63:0] cnum [FRAME_MAX/2];
		logic [63:0] cden [FRAME_MAX/2];
		logic [63:0] acc;
		logic [63:0] run_sum;
		logic [63:0] delta;
		logic [63:0] dividend;
		int          lags;
		int          hit;
		pitch_t      r;
		lags = frame_len / 2;
		run_sum = 0;
		hit = -1;
		for (int t = 1; t < lags; t++) begin
			acc = 0;
			for (int i = 0; i + t < frame_len; i++) begin
				delta = 64'(longint'(frame_buf[i]) - longint'(frame_buf[i + t]));
				acc += delta * delta;
			end
			run_sum += acc;
			if (run_sum == 0) begin
				cnum[t] = 1;
				cden[t] = 1;
			end else begin
				cnum[t] = acc * 64'(t);
				cden[t] = run_sum;
			end
		end
		for (int t = 2; t < lags && hit < 0; t++) begin
			if (frac_below(cnum[t], cden[t], 64'(thr_reg), 64'(THR_ONE))) begin
				while (t + 1 < lags && frac_below(cnum[t+1], cden[t+1], cnum[t], cden[t]))
					t++;
				hit = t;
			end
		end
		r = '0;
		if (hit >= 0) begin
			dividend = 64'(rate_reg) * 256 + 64'(hit / 2);
			r.found = 1'b1;
			r.period = PERIOD_W'(hit);
			r.freq = FREQ_W'(dividend / 64'(hit));
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		mismatches++;
	endtask

	// result checker
	always @(posedge clk) begin
		pitch_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pitch_queue.size() == 0) begin
				report_mismatch("unexpected result, found", found, 0);
			end else begin
				want = pitch_queue.pop_front();
				if (found !== want.found)
					report_mismatch("found", found, want.found);
				if (period !== want.period)
					report_mismatch("period", period, want.period);
				if (frequency_q8 !== want.freq)
					report_mismatch("frequency_q8", frequency_q8, want.freq);
			end
		end
	end

	// receiver stall pattern, with one long hold-off on request
	initial begin
		int mode;
		int span;
		result_stall = 1'b0;
		forever begin
			if (hold_request) begin
				hold_request = 0;
				@(negedge clk);
				result_stall <= 1'b1;
				repeat (30000) @(negedge clk);
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 300);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0: result_stall <= 1'b0;
					1: result_stall <= ($urandom_range(0, 9) < 3);
					2: result_stall <= ($urandom_range(0, 9) < 8);
					default: result_stall <= ($urandom_range(0, 1) == 1);
				endcase
			end
		end
	end

	// one sample request; sender bursts with random gaps
	task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic l, logic typed,
			pitch_t typed_res);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				sample_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		sample_valid <= 1'b1;
		sample <= s;
		last <= l;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		// request accepted
		if (frame_len < FRAME_MAX) begin
			frame_buf[frame_len] = int'(s);
			frame_len++;
		end
		items_sent++;
		if (l) begin
			pitch_queue.push_back(typed ? typed_res : analyze_frame());
			frame_len = 0;
			frames_sent++;
		end
		burst_left--;
		@(negedge clk);
	endtask

	// let the block finish before touching its registers
	task automatic drain();
		sample_valid <= 1'b0;
		burst_left = 0;
		while (pitch_queue.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_SAMPLE_RATE)
			rate_reg = RATE_W'(val);
		else if (idx == REG_THRESHOLD)
			thr_reg = THR_W'(val);
	endtask

	// random frame: tones, noise, flat lines and full-scale swings
	task automatic send_frame(int len);
		int kind;
		int per;
		int amp;
		int noise;
		int v;
		pitch_t none;
		none = '0;
		kind = $urandom_range(0, 9);
		per = $urandom_range(2, (len > 8) ? len / 2 : 4);
		amp = $urandom_range(1, 32767);
		noise = $urandom_range(0, 3) == 0 ? $urandom_range(0, 4000) : $urandom_range(0, 30);
		for (int i = 0; i < len; i++) begin
			case (kind)
				0, 1, 2: v = ((i % per) < per / 2) ? amp : -amp;
				3, 4, 5: v = ((i % per) * 2 * amp) / per - amp;
				6: v = int'($urandom_range(0, 65535)) - 32768;
				7: v = amp;
				8: v = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
				default: v = ((i % per) == 0) ? amp : 0;
			endcase
			if (kind <= 5)
				v += int'($urandom_range(0, 2 * noise)) - noise;
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
			send_sample(SAMPLE_W'(v), i == len - 1, 1'b0, none);
		end
	endtask

	stim_row_t directed [$];

	task automatic add_row(int s, logic l, logic typed);
		stim_row_t row;
		row.smp = SAMPLE_W'(s);
		row.lst = l;
		row.typed = typed;
		row.res = '0;
		directed.push_back(row);
	endtask

	initial begin
		logic [RATE_W-1:0] rates [5];
		logic [THR_W-1:0]  thrs [5];
		int                len;
		int                item_mark;
		int                frame_mark;
		mismatches = 0;
		items_sent = 0;
		frames_sent = 0;
		burst_left = 0;
		frame_len = 0;
		hold_request = 0;
		rate_reg = RATE_RESET;
		thr_reg = THR_RESET;
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		last = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_SAMPLE_RATE;
		cfg_data = '0;

		// single-sample frame and a three-sample frame: too short, nothing found
		add_row(-32768, 1, 1);
		add_row(32767, 0, 0);
		add_row(-32768, 0, 0);
		add_row(32767, 1, 1);
		// flat frame: zero running sum, never below threshold
		for (int i = 0; i < 8; i++) add_row(0, i == 7, 1);
		// full-scale alternation with period 3, checked by the predictor
		for (int i = 0; i < 12; i++) add_row((i % 3 == 0) ? 32767 : -32768, i == 11, 0);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[k])
			send_sample(directed[k].smp, directed[k].lst, directed[k].typed, directed[k].res);
		drain();

		rates = '{RATE_RESET, 18'd192000, 18'd1, 18'd0, RATE_W'($urandom_range(8000, 96000))};
		thrs = '{THR_RESET, 16'd65535, 16'd1, THR_W'($urandom_range(2000, 30000)),
			THR_W'($urandom_range(1, 65535))};
		for (int ph = 0; ph < 5; ph++) begin
			if (ph > 0) begin
				write_reg(REG_SAMPLE_RATE, CFG_DATA_W'(rates[ph]));
				write_reg(REG_THRESHOLD, CFG_DATA_W'(thrs[ph]));
			end
			// overflowing frame once, long hold-off once
			if (ph == 1)
				send_frame(FRAME_MAX + 6);
			if (ph == 2)
				hold_request = 1;
			item_mark = items_sent;
			frame_mark = frames_sent;
			while (items_sent < item_mark + 110 || frames_sent < frame_mark + 3) begin
				case ($urandom_range(0, 19))
					0: len = $urandom_range(1, 3);
					1: len = $urandom_range(100, 200);
					default: len = $urandom_range(4, 48);
				endcase
				send_frame(len);
			end
			drain();
		end

		repeat (200) @(negedge clk);
		if (mismatches == 0 && pitch_queue.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/yin_pkg.sv
sv/yin_mul.sv
sv/yin_div.sv
sv/yin_pitch_detector_unit.sv
verif/yin_pitch_detector_unit_test.sv
